// File: src/rx_payload_checksum_deframer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the payload checksum deframer
// Shared concurrent assertion forms, sampled on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RX_PAYLOAD_CHECKSUM_DEFRAMER_CORE_MACROS_SVH
`define RX_PAYLOAD_CHECKSUM_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication
`define RPCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication
`define RPCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// File: src/rpcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcd_pkg
// Constants, types and helpers shared by the deframer front, queue and back.
// ----------------------------------------------------------------------------
package rpcd_pkg;

    localparam int MAX_PAYLOAD_DATA = 30;
    // Pipe FIFO depth must be a power of two: pointers wrap by width
    localparam int PIPE_FIFO_DEPTH  = 32;
    localparam int PIPE_COUNT       = 6;

    localparam int PIPE_W      = 3;
    localparam int BYTE_W      = 8;
    localparam int ERR_W       = 16;
    localparam int LEVEL_W     = 6;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD_DATA + 1);
    localparam int SIDX_W      = $clog2(MAX_PAYLOAD_DATA);
    localparam int PTR_W       = $clog2(PIPE_FIFO_DEPTH);
    localparam int FILL_W      = PTR_W + 1;
    localparam int STORE_DEPTH = PIPE_COUNT * PIPE_FIFO_DEPTH;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // Command queue between front and back, power of two deep
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DATA,
        PH_CHECK
    } phase_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_POP,
        OP_STAGE,
        OP_COMMIT
    } op_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_POP,
        BK_CM_RD,
        BK_CM_WR,
        BK_REPORT
    } back_state_t;

    // One classified word handed from front to back
    typedef struct packed {
        op_t                 op;
        logic [PIPE_W-1:0]   pipe;
        logic                pipe_vld;
        logic [SIDX_W-1:0]   idx;
        logic [BYTE_W-1:0]   data;
        logic [CNT_W-1:0]    len;
        logic [PIPE_W-1:0]   fp;
        logic                done;
        logic                ok;
        logic [ERR_W-1:0]    err;
    } cmd_t;

    function automatic logic pipe_valid(input logic [PIPE_W-1:0] p);
        return int'(p) < PIPE_COUNT;
    endfunction

    function automatic logic [STORE_AW-1:0] store_addr(input logic [PIPE_W-1:0] p,
                                                       input logic [PTR_W-1:0] ptr);
        return STORE_AW'(int'(p) * PIPE_FIFO_DEPTH + int'(ptr));
    endfunction

endpackage

// File: src/rpcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcd_front
// Accepts words, tracks payload framing and checksum, counts errors and
// turns each word into one command for the back end.
// ----------------------------------------------------------------------------
module rpcd_front
    import rpcd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_func,
    input  logic [PIPE_W-1:0]   in_pipe,
    input  logic                in_first,
    input  logic [BYTE_W-1:0]   in_byte,
    input  logic                cmd_ready,
    output logic                cmd_push,
    output cmd_t                cmd_data
);

    phase_t              phase_reg, phase_next;
    logic [CNT_W-1:0]    exp_reg, exp_next;
    logic [CNT_W-1:0]    rcv_reg, rcv_next;
    logic [BYTE_W-1:0]   sum_reg, sum_next;
    logic [PIPE_W-1:0]   fpipe_reg, fpipe_next;
    logic [ERR_W-1:0]    err_reg, err_next;

    logic                acc;
    logic                in_pvld;
    logic                cnt_too_big;
    logic [CNT_W-1:0]    rcv_inc;

    assign in_ready    = cmd_ready;
    assign acc         = in_valid & cmd_ready;
    assign cmd_push    = acc;
    assign in_pvld     = pipe_valid(in_pipe);
    assign cnt_too_big = in_byte > BYTE_W'(MAX_PAYLOAD_DATA);
    assign rcv_inc     = rcv_reg + CNT_W'(1);

    // Next framing phase
    always_comb
    begin
        phase_next = phase_reg;
        if (acc && !in_func)
        begin
            if (in_first)
            begin
                phase_next = PH_IDLE;
                if (in_pvld && !cnt_too_big)
                begin
                    phase_next = (in_byte == '0) ? PH_CHECK : PH_DATA;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_DATA:
                    begin
                        if (rcv_inc >= exp_reg)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK: phase_next = PH_IDLE;
                    default:  phase_next = phase_reg;
                endcase
            end
        end
    end

    // Classify the word, update counts and sum, build the command
    always_comb
    begin
        exp_next   = exp_reg;
        rcv_next   = rcv_reg;
        sum_next   = sum_reg;
        fpipe_next = fpipe_reg;
        err_next   = err_reg;

        cmd_data          = '0;
        cmd_data.op       = OP_NONE;
        cmd_data.pipe     = in_pipe;
        cmd_data.pipe_vld = in_pvld;
        cmd_data.idx      = SIDX_W'(rcv_reg);
        cmd_data.data     = in_byte;
        cmd_data.len      = exp_reg;
        cmd_data.fp       = fpipe_reg;

        if (in_func)
        begin
            cmd_data.op = OP_POP;
        end
        else if (in_first)
        begin
            if (in_pvld)
            begin
                fpipe_next = in_pipe;
                if (cnt_too_big)
                begin
                    err_next      = err_reg + ERR_W'(1);
                    cmd_data.done = 1'b1;
                end
                else
                begin
                    exp_next = CNT_W'(in_byte);
                    rcv_next = '0;
                    sum_next = in_byte;
                end
            end
        end
        else
        begin
            case (phase_reg)
                PH_DATA:
                begin
                    cmd_data.op = OP_STAGE;
                    sum_next    = sum_reg + in_byte;
                    rcv_next    = rcv_inc;
                end
                PH_CHECK:
                begin
                    cmd_data.done = 1'b1;
                    if (in_byte == ~sum_reg)
                    begin
                        cmd_data.ok = 1'b1;
                        cmd_data.op = OP_COMMIT;
                    end
                    else
                    begin
                        err_next = err_reg + ERR_W'(1);
                    end
                end
                default: cmd_data.op = OP_NONE;
            endcase
        end
        cmd_data.err = err_next;
    end

    // Framing registers advance only on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            exp_reg   <= '0;
            rcv_reg   <= '0;
            sum_reg   <= '0;
            fpipe_reg <= '0;
            err_reg   <= '0;
        end
        else if (acc)
        begin
            phase_reg <= phase_next;
            exp_reg   <= exp_next;
            rcv_reg   <= rcv_next;
            sum_reg   <= sum_next;
            fpipe_reg <= fpipe_next;
            err_reg   <= err_next;
        end
    end

endmodule

// File: src/rpcd_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcd_cmd_fifo
// Short command queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
module rpcd_cmd_fifo
    import rpcd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_valid,
    output logic    wr_ready,
    input  cmd_t    wr_data,
    output logic    rd_valid,
    input  logic    rd_pop,
    output cmd_t    rd_data
);

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]    wr_ptr_reg;
    logic [CMDQ_AW-1:0]    rd_ptr_reg;
    logic [CMDQ_AW:0]      count_reg, count_next;
    logic                  do_wr;
    logic                  do_rd;

    assign wr_ready = count_reg != (CMDQ_AW + 1)'(CMDQ_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid & wr_ready;
    assign do_rd    = rd_pop & rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (CMDQ_AW + 1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (CMDQ_AW + 1)'(1);
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + CMDQ_AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + CMDQ_AW'(1);
            end
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: src/rpcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcd_back
// Executes commands: stages data bytes, commits a good payload into its pipe
// FIFO one byte at a time, serves pops and registers one result per command.
// ----------------------------------------------------------------------------
module rpcd_back
    import rpcd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  cmd_t                cmd_data,
    output logic                cmd_pop,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [BYTE_W-1:0]   read_data,
    output logic                read_valid,
    output logic [LEVEL_W-1:0]  pipe_level,
    output logic                payload_done,
    output logic                payload_ok,
    output logic [ERR_W-1:0]    error_count
);

    back_state_t           state_reg, state_next;
    cmd_t                  cmd_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  popped_reg;
    logic [BYTE_W-1:0]     rd_data_reg;
    logic [BYTE_W-1:0]     st_rd_reg;

    logic [PTR_W-1:0]      head_reg [PIPE_COUNT];
    logic [PTR_W-1:0]      tail_reg [PIPE_COUNT];
    logic [FILL_W-1:0]     fill_reg [PIPE_COUNT];

    logic [BYTE_W-1:0]     stage_mem [MAX_PAYLOAD_DATA];
    logic [BYTE_W-1:0]     store_mem [STORE_DEPTH];

    logic                  out_vld_reg;
    logic [BYTE_W-1:0]     out_data_reg;
    logic                  out_rvld_reg;
    logic [LEVEL_W-1:0]    out_level_reg;
    logic                  out_done_reg;
    logic                  out_ok_reg;
    logic [ERR_W-1:0]      out_err_reg;

    logic [PIPE_W-1:0]     sel_pipe;
    logic                  sel_ok;
    logic [FILL_W-1:0]     sel_fill;
    logic [PTR_W-1:0]      sel_head;
    logic [PTR_W-1:0]      sel_tail;
    logic                  can_pop;
    logic                  out_free;
    logic                  last_byte;
    logic                  rd_en;
    logic                  stage_we;
    logic                  push_we;
    logic                  load_out;

    // Pick the one pipe whose pointers are in use this cycle
    always_comb
    begin
        case (state_reg)
            BK_IDLE:            sel_pipe = cmd_data.pipe;
            BK_CM_RD, BK_CM_WR: sel_pipe = cmd_reg.fp;
            default:            sel_pipe = cmd_reg.pipe;
        endcase
    end

    assign sel_ok    = pipe_valid(sel_pipe);
    assign sel_fill  = sel_ok ? fill_reg[sel_pipe] : '0;
    assign sel_head  = sel_ok ? head_reg[sel_pipe] : '0;
    assign sel_tail  = sel_ok ? tail_reg[sel_pipe] : '0;
    assign can_pop   = cmd_data.pipe_vld && (sel_fill != '0);
    assign out_free  = !out_vld_reg || res_ready;
    assign last_byte = (cnt_reg + CNT_W'(1)) == cmd_reg.len;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd_data.op)
                        OP_POP:    state_next = can_pop ? BK_POP : BK_REPORT;
                        OP_COMMIT: state_next = (cmd_data.len != '0) ? BK_CM_RD : BK_REPORT;
                        default:   state_next = BK_REPORT;
                    endcase
                end
            end
            BK_POP:    state_next = BK_REPORT;
            BK_CM_RD:  state_next = BK_CM_WR;
            BK_CM_WR:  state_next = last_byte ? BK_REPORT : BK_CM_RD;
            BK_REPORT: state_next = out_free ? BK_IDLE : BK_REPORT;
            default:   state_next = BK_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        cmd_pop  = 1'b0;
        rd_en    = 1'b0;
        stage_we = 1'b0;
        push_we  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                cmd_pop  = cmd_valid;
                rd_en    = cmd_valid && (cmd_data.op == OP_POP) && can_pop;
                stage_we = cmd_valid && (cmd_data.op == OP_STAGE);
            end
            BK_CM_WR:  push_we  = sel_fill < FILL_W'(PIPE_FIFO_DEPTH);
            BK_REPORT: load_out = out_free;
            default:   cmd_pop  = 1'b0;
        endcase
    end

    // Control registers and pipe pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < PIPE_COUNT; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (rd_en)
            begin
                head_reg[sel_pipe] <= sel_head + PTR_W'(1);
                fill_reg[sel_pipe] <= sel_fill - FILL_W'(1);
            end
            if (push_we)
            begin
                tail_reg[sel_pipe] <= sel_tail + PTR_W'(1);
                fill_reg[sel_pipe] <= sel_fill + FILL_W'(1);
            end
        end
    end

    // Command hold, commit counter and result register
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg    <= cmd_data;
            popped_reg <= rd_en;
            cnt_reg    <= '0;
        end
        else if (state_reg == BK_CM_WR)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (load_out)
        begin
            out_data_reg  <= popped_reg ? rd_data_reg : '0;
            out_rvld_reg  <= popped_reg;
            out_level_reg <= cmd_reg.pipe_vld ? LEVEL_W'(sel_fill) : '0;
            out_done_reg  <= cmd_reg.done;
            out_ok_reg    <= cmd_reg.ok;
            out_err_reg   <= cmd_reg.err;
        end
    end

    // Staging buffer: written by data words, read during commit
    always_ff @(posedge clk)
    begin
        if (stage_we)
        begin
            stage_mem[cmd_data.idx] <= cmd_data.data;
        end
        if (state_reg == BK_CM_RD)
        begin
            st_rd_reg <= stage_mem[SIDX_W'(cnt_reg)];
        end
    end

    // Pipe store: commit writes at the tail, pops read at the head
    always_ff @(posedge clk)
    begin
        if (push_we)
        begin
            store_mem[store_addr(sel_pipe, sel_tail)] <= st_rd_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[store_addr(sel_pipe, sel_head)];
        end
    end

    assign res_valid    = out_vld_reg;
    assign read_data    = out_data_reg;
    assign read_valid   = out_rvld_reg;
    assign pipe_level   = out_level_reg;
    assign payload_done = out_done_reg;
    assign payload_ok   = out_ok_reg;
    assign error_count  = out_err_reg;

endmodule

// File: src/rx_payload_checksum_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_payload_checksum_deframer_core
// Receive payload deframer with inverted-sum checksum and per-pipe FIFOs.
// ----------------------------------------------------------------------------
// Every input word yields exactly one result word. The front classifies each
// word in the cycle it is accepted and queues a command in a two-entry queue,
// so it takes one word per cycle while the queue has room. The back end sets
// the sustained rate. A data byte, a header, a non-payload word, or a pop of
// an empty or invalid pipe goes from idle straight to the report state. A pop
// that returns a byte passes through the pop state first. A checksum word that
// passes for a payload of N data bytes (N up to 30) alternates the commit read
// and write states per byte: each staged byte is read from the staging buffer
// and then written to the pipe store in the next cycle. A registered output
// stage lets the back start the next word while a result waits to be taken.
// ----------------------------------------------------------------------------
module rx_payload_checksum_deframer_core
    import rpcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic [4:0]  s_tuser,   // [0] func, [3:1] pipe, [4] first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] read_data, [13:8] pipe_level,
                                   // [29:14] error_count, [31:30] zero
    output logic [2:0]  m_tuser    // [0] read_valid, [1] payload_done, [2] payload_ok
);

    logic                  fq_push;
    logic                  fq_ready;
    cmd_t                  fq_data;
    logic                  qb_valid;
    logic                  qb_pop;
    cmd_t                  qb_data;

    logic [BYTE_W-1:0]     read_data;
    logic                  read_valid;
    logic [LEVEL_W-1:0]    pipe_level;
    logic                  payload_done;
    logic                  payload_ok;
    logic [ERR_W-1:0]      error_count;

    rpcd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser[0]),
        .in_pipe   (s_tuser[3:1]),
        .in_first  (s_tuser[4]),
        .in_byte   (s_tdata),
        .cmd_ready (fq_ready),
        .cmd_push  (fq_push),
        .cmd_data  (fq_data)
    );

    rpcd_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_push),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_pop   (qb_pop),
        .rd_data  (qb_data)
    );

    rpcd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (qb_valid),
        .cmd_data     (qb_data),
        .cmd_pop      (qb_pop),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .read_data    (read_data),
        .read_valid   (read_valid),
        .pipe_level   (pipe_level),
        .payload_done (payload_done),
        .payload_ok   (payload_ok),
        .error_count  (error_count)
    );

    // Pack the result word
    assign m_tdata = {2'b00, error_count, pipe_level, read_data};
    assign m_tuser = {payload_ok, payload_done, read_valid};

endmodule

// File: src/rpcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcd_checker
// Port-level checks on the deframer result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "rx_payload_checksum_deframer_core_macros.svh"

module rpcd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [2:0]  m_tuser
);

    // Hold a stalled result
    `RPCD_ASSERT_NEXT(a_hold_result, m_tvalid && !m_tready, m_tvalid)
    // A popped byte never comes with a payload verdict
    `RPCD_ASSERT_NOW(a_pop_no_verdict, m_tvalid && m_tuser[0], !m_tuser[1])
    // A pass verdict only on a finished payload
    `RPCD_ASSERT_NOW(a_ok_needs_done, m_tvalid && m_tuser[2], m_tuser[1])
    // No data without a pop
    `RPCD_ASSERT_NOW(a_zero_data, m_tvalid && !m_tuser[0], m_tdata[7:0] == 8'h00)
    // After a pop the pipe cannot be full
    `RPCD_ASSERT_NOW(a_pop_level, m_tvalid && m_tuser[0], m_tdata[13:8] < 6'd32)

endmodule

bind rx_payload_checksum_deframer_core rpcd_checker u_rpcd_checker (.*);
